@@ rtl/cpl_pkg.sv @@
// ----------------------------------------------------------------------------
// cpl_pkg
// shared constants, register codes and types of the point-to-line core
// ----------------------------------------------------------------------------
package cpl_pkg;

   localparam int COORD_WIDTH_DEFAULT     = 32;
   localparam int COORD_FRAC_BITS_DEFAULT = 16;
   localparam int QUEUE_DEPTH             = 4;
   localparam int CSR_INDEX_WIDTH         = 3;

   typedef enum logic [CSR_INDEX_WIDTH-1:0] {
      CSR_X_LOW   = 3'd0,
      CSR_X_HIGH  = 3'd1,
      CSR_Y_LOW   = 3'd2,
      CSR_Y_HIGH  = 3'd3,
      CSR_Z_SCALE = 3'd4
   } csr_index_type;

   typedef struct packed {
      logic full;
      logic empty;
   } qstat_type;

   // width of one classified item held in the queue
   function automatic int item_width(input int w);
      return 9 * w + 7;
   endfunction

endpackage

@@ rtl/cpl_front.sv @@
// ----------------------------------------------------------------------------
// cpl_front
// configuration registers, clamping and classification of incoming points
// ----------------------------------------------------------------------------
module cpl_front #(
   parameter int COORD_WIDTH     = cpl_pkg::COORD_WIDTH_DEFAULT,
   parameter int COORD_FRAC_BITS = cpl_pkg::COORD_FRAC_BITS_DEFAULT
) (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    csr_valid,
   output logic                                    csr_ready,
   input  logic [cpl_pkg::CSR_INDEX_WIDTH-1:0]     csr_index,
   input  logic [COORD_WIDTH-1:0]                  csr_data,
   input  logic                                    req_valid,
   output logic                                    req_ready,
   input  logic signed [COORD_WIDTH-1:0]           req_hand_x,
   input  logic signed [COORD_WIDTH-1:0]           req_hand_y,
   input  logic signed [COORD_WIDTH-1:0]           req_hand_z,
   input  logic signed [COORD_WIDTH-1:0]           req_line_start_x,
   input  logic signed [COORD_WIDTH-1:0]           req_line_start_y,
   input  logic signed [COORD_WIDTH-1:0]           req_line_end_x,
   input  logic signed [COORD_WIDTH-1:0]           req_line_end_y,
   input  cpl_pkg::qstat_type                      q_stat,
   output logic                                    push,
   output logic [cpl_pkg::item_width(COORD_WIDTH)-1:0] item,
   output logic [COORD_WIDTH-1:0]                  z_scale
);
   import cpl_pkg::*;

   localparam int W = COORD_WIDTH;
   localparam int F = COORD_FRAC_BITS;

   typedef struct packed {
      logic [W-1:0]        wmag0;
      logic [W-1:0]        wmag1;
      logic [W-1:0]        vmag0;
      logic [W-1:0]        vmag1;
      logic [W-1:0]        hzmag;
      logic                s1;
      logic                s2;
      logic                v0neg;
      logic                v1neg;
      logic                hzneg;
      logic signed [W-1:0] p0x;
      logic signed [W-1:0] p0y;
      logic signed [W-1:0] hx;
      logic signed [W-1:0] hy;
      logic                degen;
      logic                badscale;
   } item_type;

   logic signed [W-1:0] x_low_ff, x_high_ff, y_low_ff, y_high_ff;
   logic [W-1:0]        z_scale_ff;
   logic                f_valid_ff, f_valid_in;
   item_type            f_item_ff, f_item_in;
   logic                accept;
   logic signed [W-1:0] cx0, cx, cy0, cy;
   logic signed [W:0]   v0, v1, w0, w1, hzn;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         x_low_ff   <= {1'b1, {(W-1){1'b0}}};
         x_high_ff  <= {1'b0, {(W-1){1'b1}}};
         y_low_ff   <= {1'b1, {(W-1){1'b0}}};
         y_high_ff  <= {1'b0, {(W-1){1'b1}}};
         z_scale_ff <= {{(W-1){1'b0}}, 1'b1} << F;
      end else if (csr_valid) begin
         unique case (csr_index)
            CSR_X_LOW:   x_low_ff   <= csr_data;
            CSR_X_HIGH:  x_high_ff  <= csr_data;
            CSR_Y_LOW:   y_low_ff   <= csr_data;
            CSR_Y_HIGH:  y_high_ff  <= csr_data;
            CSR_Z_SCALE: z_scale_ff <= csr_data;
            default: ;
         endcase
      end
   end

   assign z_scale = z_scale_ff;

   // low bound first, then high bound
   always_comb begin
      cx0 = (req_hand_x < x_low_ff) ? x_low_ff : req_hand_x;
      cx  = (cx0 > x_high_ff) ? x_high_ff : cx0;
      cy0 = (req_hand_y < y_low_ff) ? y_low_ff : req_hand_y;
      cy  = (cy0 > y_high_ff) ? y_high_ff : cy0;
      v0  = {req_line_end_x[W-1], req_line_end_x} - {req_line_start_x[W-1], req_line_start_x};
      v1  = {req_line_end_y[W-1], req_line_end_y} - {req_line_start_y[W-1], req_line_start_y};
      w0  = {cx[W-1], cx} - {req_line_start_x[W-1], req_line_start_x};
      w1  = {cy[W-1], cy} - {req_line_start_y[W-1], req_line_start_y};
      hzn = -{req_hand_z[W-1], req_hand_z};
      f_item_in.wmag0    = w0[W] ? W'(-w0) : w0[W-1:0];
      f_item_in.wmag1    = w1[W] ? W'(-w1) : w1[W-1:0];
      f_item_in.vmag0    = v0[W] ? W'(-v0) : v0[W-1:0];
      f_item_in.vmag1    = v1[W] ? W'(-v1) : v1[W-1:0];
      f_item_in.hzmag    = req_hand_z[W-1] ? hzn[W-1:0] : req_hand_z;
      f_item_in.s1       = w0[W] ^ v0[W];
      f_item_in.s2       = w1[W] ^ v1[W];
      f_item_in.v0neg    = v0[W];
      f_item_in.v1neg    = v1[W];
      f_item_in.hzneg    = req_hand_z[W-1];
      f_item_in.p0x      = req_line_start_x;
      f_item_in.p0y      = req_line_start_y;
      f_item_in.hx       = cx;
      f_item_in.hy       = cy;
      f_item_in.degen    = (v0 == '0) && (v1 == '0);
      f_item_in.badscale = (z_scale_ff == '0);
   end

   assign push       = f_valid_ff && !q_stat.full;
   assign req_ready  = !f_valid_ff || !q_stat.full;
   assign accept     = req_valid && req_ready;
   assign f_valid_in = accept || (f_valid_ff && !push);

   always_ff @(posedge clock) begin
      if (reset) begin
         f_valid_ff <= 1'b0;
      end else begin
         f_valid_ff <= f_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         f_item_ff <= f_item_in;
      end
   end

   assign item = f_item_ff;

endmodule

@@ rtl/cpl_queue.sv @@
// ----------------------------------------------------------------------------
// cpl_queue
// small first-in first-out buffer between the front and back parts
// ----------------------------------------------------------------------------
module cpl_queue #(
   parameter int ITEM_W = 295,
   parameter int DEPTH  = cpl_pkg::QUEUE_DEPTH
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   input  logic [ITEM_W-1:0]  wr_item,
   input  logic               pop,
   output logic [ITEM_W-1:0]  rd_item,
   output cpl_pkg::qstat_type q_stat
);
   import cpl_pkg::*;

   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   logic [ITEM_W-1:0] mem_ff [DEPTH];
   logic [AW-1:0]     wr_ptr_ff, rd_ptr_ff;
   logic [CW-1:0]     count_ff;

   assign q_stat.full  = (count_ff == CW'(DEPTH));
   assign q_stat.empty = (count_ff == '0);
   assign rd_item      = mem_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= wr_item;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= (wr_ptr_ff == AW'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
         end
         if (pop) begin
            rd_ptr_ff <= (rd_ptr_ff == AW'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
         end
         if (push && !pop) begin
            count_ff <= count_ff + 1'b1;
         end else if (pop && !push) begin
            count_ff <= count_ff - 1'b1;
         end
      end
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(DEPTH)) else $error("queue count beyond depth");

   a_push_fills: assert property (@(posedge clock) disable iff (reset)
      push && !pop |=> !q_stat.empty) else $error("queue empty after transfer in");

endmodule

@@ rtl/cpl_div.sv @@
// ----------------------------------------------------------------------------
// cpl_div
// pipelined restoring divider, one quotient bit per stage, rounded quotient
// ----------------------------------------------------------------------------
module cpl_div #(
   parameter int NW = 97,
   parameter int DW = 65,
   parameter int QW = 48
) (
   input  logic          clock,
   input  logic          en,
   input  logic [NW-1:0] num,
   input  logic [DW-1:0] den,
   output logic [QW:0]   quo
);
   import cpl_pkg::*;

   logic [DW-1:0]    rem_ff  [QW];
   logic [QW-1:0]    word_ff [QW];
   logic [DW-1:0]    den_ff  [QW];
   logic [DW-1:0]    rem_src [QW];
   logic [QW-1:0]    word_src[QW];
   logic [DW-1:0]    den_src [QW];
   logic [NW+DW-1:0] nx;
   logic [DW:0]      rtrial;
   logic             rnd;
   logic [QW:0]      quo_ff;

   // the quotient fits in QW bits, so the top numerator bits start below den
   assign nx = {{DW{1'b0}}, num};

   genvar k;
   generate
      for (k = 0; k < QW; k++) begin : g_stage
         logic [DW:0] trial, diff;
         logic        ge;
         if (k == 0) begin : g_first
            assign rem_src[k]  = nx[QW +: DW];
            assign word_src[k] = num[QW-1:0];
            assign den_src[k]  = den;
         end else begin : g_next
            assign rem_src[k]  = rem_ff[k-1];
            assign word_src[k] = word_ff[k-1];
            assign den_src[k]  = den_ff[k-1];
         end
         assign trial = {rem_src[k], word_src[k][QW-1]};
         assign diff  = trial - {1'b0, den_src[k]};
         assign ge    = (trial >= {1'b0, den_src[k]});
         always_ff @(posedge clock) begin
            if (en) begin
               rem_ff[k]  <= ge ? diff[DW-1:0] : trial[DW-1:0];
               word_ff[k] <= {word_src[k][QW-2:0], ge};
               den_ff[k]  <= den_src[k];
            end
         end
      end
   endgenerate

   // round half away from zero on the magnitude
   assign rtrial = {rem_ff[QW-1], 1'b0};
   assign rnd    = (rtrial >= {1'b0, den_ff[QW-1]});

   always_ff @(posedge clock) begin
      if (en) begin
         quo_ff <= {1'b0, word_ff[QW-1]} + (QW+1)'(rnd);
      end
   end

   assign quo = quo_ff;

endmodule

@@ rtl/cpl_back.sv @@
// ----------------------------------------------------------------------------
// cpl_back
// dot products, projection offsets, z scaling and the result register
// ----------------------------------------------------------------------------
module cpl_back #(
   parameter int COORD_WIDTH     = cpl_pkg::COORD_WIDTH_DEFAULT,
   parameter int COORD_FRAC_BITS = cpl_pkg::COORD_FRAC_BITS_DEFAULT
) (
   input  logic                                        clock,
   input  logic                                        reset,
   input  logic [cpl_pkg::item_width(COORD_WIDTH)-1:0] q_item,
   input  cpl_pkg::qstat_type                          q_stat,
   output logic                                        pop,
   input  logic [COORD_WIDTH-1:0]                      z_scale,
   output logic                                        rsp_valid,
   input  logic                                        rsp_ready,
   output logic signed [COORD_WIDTH-1:0]               rsp_out_x,
   output logic signed [COORD_WIDTH-1:0]               rsp_out_y,
   output logic signed [COORD_WIDTH-1:0]               rsp_out_z,
   output logic                                        rsp_line_degenerate,
   output logic                                        rsp_scale_invalid
);
   import cpl_pkg::*;

   localparam int W  = COORD_WIDTH;
   localparam int F  = COORD_FRAC_BITS;
   localparam int QW = W + F;
   localparam int NW = 3 * W + 1;
   localparam int DW = 2 * W + 1;
   localparam int NZ = W + F;
   localparam int SW = QW + 2;
   localparam logic signed [SW-1:0] SMAX = {{(SW-W+1){1'b0}}, {(W-1){1'b1}}};
   localparam logic signed [SW-1:0] SMIN = {{(SW-W+1){1'b1}}, {(W-1){1'b0}}};

   typedef struct packed {
      logic [W-1:0]        wmag0;
      logic [W-1:0]        wmag1;
      logic [W-1:0]        vmag0;
      logic [W-1:0]        vmag1;
      logic [W-1:0]        hzmag;
      logic                s1;
      logic                s2;
      logic                v0neg;
      logic                v1neg;
      logic                hzneg;
      logic signed [W-1:0] p0x;
      logic signed [W-1:0] p0y;
      logic signed [W-1:0] hx;
      logic signed [W-1:0] hy;
      logic                degen;
      logic                badscale;
   } item_type;

   typedef struct packed {
      logic                negx;
      logic                negy;
      logic                negz;
      logic                degen;
      logic                badscale;
      logic signed [W-1:0] p0x;
      logic signed [W-1:0] p0y;
      logic signed [W-1:0] hx;
      logic signed [W-1:0] hy;
   } side_type;

   function automatic logic [W-1:0] sat_fn(input logic signed [SW-1:0] v);
      logic signed [SW-1:0] r;
      r = (v > SMAX) ? SMAX : ((v < SMIN) ? SMIN : v);
      return r[W-1:0];
   endfunction

   item_type           qi;
   logic               adv;

   logic               a_vld_ff;
   item_type           a_item_ff;
   logic [2*W-1:0]     a_pa_ff, a_pb_ff, a_sa_ff, a_sb_ff;

   logic               b_vld_ff;
   logic [DW-1:0]      b_num_ff, b_den_ff, b_num_in;
   logic [W-1:0]       b_vm0_ff, b_vm1_ff, b_hzm_ff;
   side_type           b_side_ff, b_side_in;
   logic               sn;

   logic               c_vld_ff;
   logic [2*W-1:0]     c_plx_ff, c_ply_ff;
   logic [2*W:0]       c_phx_ff, c_phy_ff;
   logic [DW-1:0]      c_den_ff;
   logic [W-1:0]       c_hzm_ff;
   side_type           c_side_ff;

   logic               d_vld_ff;
   logic [NW-1:0]      d_px_ff, d_py_ff;
   logic [DW-1:0]      d_den_ff;
   logic [NZ-1:0]      d_zn_ff;
   logic [W-1:0]       d_zs_ff;
   side_type           d_side_ff;

   logic               e_vld_ff  [QW+1];
   side_type           e_side_ff [QW+1];

   logic [QW:0]        qx, qy, qz;
   logic signed [SW-1:0] sx, sy, sz;
   side_type           es;

   logic               rsp_valid_ff;
   logic signed [W-1:0] out_x_ff, out_y_ff, out_z_ff;
   logic               degen_ff, badscale_ff;

   assign qi  = q_item;
   assign adv = !rsp_valid_ff || rsp_ready;
   assign pop = adv && !q_stat.empty;

   always_comb begin
      if (a_item_ff.s1 == a_item_ff.s2) begin
         b_num_in = DW'(a_pa_ff) + DW'(a_pb_ff);
         sn       = a_item_ff.s1;
      end else if (a_pa_ff >= a_pb_ff) begin
         b_num_in = DW'(a_pa_ff - a_pb_ff);
         sn       = a_item_ff.s1;
      end else begin
         b_num_in = DW'(a_pb_ff - a_pa_ff);
         sn       = a_item_ff.s2;
      end
      b_side_in.negx     = sn ^ a_item_ff.v0neg;
      b_side_in.negy     = sn ^ a_item_ff.v1neg;
      b_side_in.negz     = a_item_ff.hzneg;
      b_side_in.degen    = a_item_ff.degen;
      b_side_in.badscale = a_item_ff.badscale;
      b_side_in.p0x      = a_item_ff.p0x;
      b_side_in.p0y      = a_item_ff.p0y;
      b_side_in.hx       = a_item_ff.hx;
      b_side_in.hy       = a_item_ff.hy;
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         a_item_ff <= qi;
         a_pa_ff   <= qi.wmag0 * qi.vmag0;
         a_pb_ff   <= qi.wmag1 * qi.vmag1;
         a_sa_ff   <= qi.vmag0 * qi.vmag0;
         a_sb_ff   <= qi.vmag1 * qi.vmag1;
         b_num_ff  <= b_num_in;
         b_den_ff  <= DW'(a_sa_ff) + DW'(a_sb_ff);
         b_vm0_ff  <= a_item_ff.vmag0;
         b_vm1_ff  <= a_item_ff.vmag1;
         b_hzm_ff  <= a_item_ff.hzmag;
         b_side_ff <= b_side_in;
         c_plx_ff  <= b_num_ff[W-1:0] * b_vm0_ff;
         c_phx_ff  <= b_num_ff[DW-1:W] * b_vm0_ff;
         c_ply_ff  <= b_num_ff[W-1:0] * b_vm1_ff;
         c_phy_ff  <= b_num_ff[DW-1:W] * b_vm1_ff;
         c_den_ff  <= b_den_ff;
         c_hzm_ff  <= b_hzm_ff;
         c_side_ff <= b_side_ff;
         d_px_ff   <= (NW'(c_phx_ff) << W) + NW'(c_plx_ff);
         d_py_ff   <= (NW'(c_phy_ff) << W) + NW'(c_ply_ff);
         d_den_ff  <= c_den_ff;
         d_zn_ff   <= {c_hzm_ff, {F{1'b0}}};
         d_zs_ff   <= z_scale;
         d_side_ff <= c_side_ff;
         e_side_ff[0] <= d_side_ff;
         for (int i = 1; i <= QW; i++) begin
            e_side_ff[i] <= e_side_ff[i-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_vld_ff <= 1'b0;
         b_vld_ff <= 1'b0;
         c_vld_ff <= 1'b0;
         d_vld_ff <= 1'b0;
         for (int i = 0; i <= QW; i++) begin
            e_vld_ff[i] <= 1'b0;
         end
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         a_vld_ff    <= pop;
         b_vld_ff    <= a_vld_ff;
         c_vld_ff    <= b_vld_ff;
         d_vld_ff    <= c_vld_ff;
         e_vld_ff[0] <= d_vld_ff;
         for (int i = 1; i <= QW; i++) begin
            e_vld_ff[i] <= e_vld_ff[i-1];
         end
         rsp_valid_ff <= e_vld_ff[QW];
      end
   end

   cpl_div #(.NW(NW), .DW(DW), .QW(QW)) u_div_x (
      .clock (clock), .en (adv), .num (d_px_ff), .den (d_den_ff), .quo (qx)
   );

   cpl_div #(.NW(NW), .DW(DW), .QW(QW)) u_div_y (
      .clock (clock), .en (adv), .num (d_py_ff), .den (d_den_ff), .quo (qy)
   );

   cpl_div #(.NW(NZ), .DW(W), .QW(QW)) u_div_z (
      .clock (clock), .en (adv), .num (d_zn_ff), .den (d_zs_ff), .quo (qz)
   );

   always_comb begin
      es = e_side_ff[QW];
      sx = {{(SW-W){es.p0x[W-1]}}, es.p0x}
         + (es.negx ? -$signed({1'b0, qx}) : $signed({1'b0, qx}));
      sy = {{(SW-W){es.p0y[W-1]}}, es.p0y}
         + (es.negy ? -$signed({1'b0, qy}) : $signed({1'b0, qy}));
      sz = es.negz ? -$signed({1'b0, qz}) : $signed({1'b0, qz});
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         out_x_ff    <= es.degen ? es.hx : sat_fn(sx);
         out_y_ff    <= es.degen ? es.hy : sat_fn(sy);
         out_z_ff    <= es.badscale ? '0 : sat_fn(sz);
         degen_ff    <= es.degen;
         badscale_ff <= es.badscale;
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_out_x           = out_x_ff;
   assign rsp_out_y           = out_y_ff;
   assign rsp_out_z           = out_z_ff;
   assign rsp_line_degenerate = degen_ff;
   assign rsp_scale_invalid   = badscale_ff;

   a_bad_scale_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && badscale_ff |-> out_z_ff == '0) else $error("z not cleared on bad scale");

endmodule

@@ rtl/clamp_and_project_point_to_line_core.sv @@
// ----------------------------------------------------------------------------
// clamp_and_project_point_to_line_core
// clamps a hand position to a plane rectangle, scales z and projects x, y
// onto the line through two points
//
// req_ carries one point and line per transfer, rsp_ one result per transfer,
// both valid/ready. csr_ writes one of five plane registers, always ready;
// write it only while no point is in flight.
// a front stage clamps and classifies each point into a four-entry queue;
// the back pipeline does the dot products, three pipelined dividers with one
// quotient bit per stage, rounding and saturation.
// throughput: one point per cycle while rsp_ready stays high. the delay from
// transfer in to rsp_valid is set mainly by the divider depth; coordinates
// default to Q16.16.
// reset empties the front, queue and pipeline and restores the plane defaults.
// when rsp_valid is high and rsp_ready is low the whole back pipeline holds,
// the queue fills and then req_ready drops; nothing is lost.
// ----------------------------------------------------------------------------
module clamp_and_project_point_to_line_core #(
   parameter int COORD_FRAC_BITS = cpl_pkg::COORD_FRAC_BITS_DEFAULT,
   parameter int COORD_WIDTH     = cpl_pkg::COORD_WIDTH_DEFAULT
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [cpl_pkg::CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [COORD_WIDTH-1:0]              csr_data,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic signed [COORD_WIDTH-1:0]       req_hand_x,
   input  logic signed [COORD_WIDTH-1:0]       req_hand_y,
   input  logic signed [COORD_WIDTH-1:0]       req_hand_z,
   input  logic signed [COORD_WIDTH-1:0]       req_line_start_x,
   input  logic signed [COORD_WIDTH-1:0]       req_line_start_y,
   input  logic signed [COORD_WIDTH-1:0]       req_line_end_x,
   input  logic signed [COORD_WIDTH-1:0]       req_line_end_y,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic signed [COORD_WIDTH-1:0]       rsp_out_x,
   output logic signed [COORD_WIDTH-1:0]       rsp_out_y,
   output logic signed [COORD_WIDTH-1:0]       rsp_out_z,
   output logic                                rsp_line_degenerate,
   output logic                                rsp_scale_invalid
);
   import cpl_pkg::*;

   localparam int ITEM_W = item_width(COORD_WIDTH);

   qstat_type               q_stat;
   logic                    push, pop;
   logic [ITEM_W-1:0]       f_item, q_item;
   logic [COORD_WIDTH-1:0]  z_scale;

   cpl_front #(.COORD_WIDTH(COORD_WIDTH), .COORD_FRAC_BITS(COORD_FRAC_BITS)) u_front (
      .clock            (clock),
      .reset            (reset),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_index        (csr_index),
      .csr_data         (csr_data),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_hand_x       (req_hand_x),
      .req_hand_y       (req_hand_y),
      .req_hand_z       (req_hand_z),
      .req_line_start_x (req_line_start_x),
      .req_line_start_y (req_line_start_y),
      .req_line_end_x   (req_line_end_x),
      .req_line_end_y   (req_line_end_y),
      .q_stat           (q_stat),
      .push             (push),
      .item             (f_item),
      .z_scale          (z_scale)
   );

   cpl_queue #(.ITEM_W(ITEM_W), .DEPTH(QUEUE_DEPTH)) u_queue (
      .clock   (clock),
      .reset   (reset),
      .push    (push),
      .wr_item (f_item),
      .pop     (pop),
      .rd_item (q_item),
      .q_stat  (q_stat)
   );

   cpl_back #(.COORD_WIDTH(COORD_WIDTH), .COORD_FRAC_BITS(COORD_FRAC_BITS)) u_back (
      .clock               (clock),
      .reset               (reset),
      .q_item              (q_item),
      .q_stat              (q_stat),
      .pop                 (pop),
      .z_scale             (z_scale),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_out_x           (rsp_out_x),
      .rsp_out_y           (rsp_out_y),
      .rsp_out_z           (rsp_out_z),
      .rsp_line_degenerate (rsp_line_degenerate),
      .rsp_scale_invalid   (rsp_scale_invalid)
   );

   a_front_holds: assert property (@(posedge clock) disable iff (reset)
      !req_ready |=> !push || $past(q_stat.full)) else $error("front released while queue full");

endmodule
